// ===== src/avcc2ab_pkg.sv =====
// Shared types and constants of the length-prefix to start-code converter.
`timescale 1ns / 1ps

package avcc2ab_pkg;

    // Outcome codes carried on the end-of-unit result
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TRUNC     = 2'd1;
    localparam logic [1:0] STAT_NO_SETS   = 2'd2;
    localparam logic [1:0] STAT_BAD_EXTRA = 2'd3;

    // Extradata layout
    localparam int SPS_LEN_POS  = 7;   // byte that holds the SPS length
    localparam int SETS_START   = 8;   // first SPS byte, also both prefixes together
    localparam int PPS_LEN_GAP  = 10;  // PPS length sits at this offset plus the SPS length
    localparam int PREFIX_BYTES = 4;   // 00 00 00 01
    localparam int LEN_BYTES    = 4;   // big-endian NAL length in a packet

    localparam int EXT_POS_W = 10;     // saturating extradata byte counter
    localparam int EXT_CMP_W = 12;     // arithmetic width of the extradata compares

    localparam logic [7:0] START_CODE_LAST = 8'h01;

    // What follows the replayed sets for one packet byte
    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_DATA = 2'd1,
        TAIL_CODE = 2'd2
    } tail_t;

    // Results that one accepted request calls for
    typedef struct packed {
        logic       replay;
        tail_t      tail;
        logic       last;
        logic [1:0] status;
        logic [7:0] data;
    } plan_t;

    // Parameter sets as seen by the replay logic
    typedef struct packed {
        logic       valid;
        logic [7:0] sps_bytes;
    } sets_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REPLAY = 4'b0010,
        ST_TAIL   = 4'b0100,
        ST_MARK   = 4'b1000
    } state_t;

endpackage

// ===== src/avcc2ab_param_store.sv =====
// Parameter set byte store: one write port, one registered read port.
`timescale 1ns / 1ps

module avcc2ab_param_store #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/avcc2ab_extra_parser.sv =====
// Extradata parser: locates SPS and PPS, fills the store, judges the unit.
`timescale 1ns / 1ps

module avcc2ab_extra_parser #(
    parameter int STORE_BYTES = 64,
    parameter int AW          = $clog2(STORE_BYTES),
    parameter int PLW         = $clog2(STORE_BYTES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 acc,
    input  logic [7:0]           data_byte,
    input  logic                 last,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [7:0]           wr_data,
    output logic [1:0]           status,
    output avcc2ab_pkg::sets_t   sets,
    output logic [PLW-1:0]       param_length
);

    localparam int CW = avcc2ab_pkg::EXT_CMP_W;

    logic [avcc2ab_pkg::EXT_POS_W-1:0] extra_pos_reg, extra_pos_next;
    logic [7:0]     sps_reg, sps_next;
    logic [7:0]     pps_reg, pps_next;
    logic           bad_reg, bad_next;
    logic           valid_reg;
    logic [PLW-1:0] param_length_reg;

    logic           first;
    logic [7:0]     eff_sps, eff_pps;
    logic           eff_bad;
    logic [CW-1:0]  pos_w, sps_w, pps_at, wr_addr_w, len_w;
    logic           wr_hit, whole, good;

    always_comb begin
        first     = (extra_pos_reg == '0);
        eff_sps   = first ? 8'd0 : sps_reg;
        eff_pps   = first ? 8'd0 : pps_reg;
        eff_bad   = first ? 1'b0 : bad_reg;
        pos_w     = CW'(extra_pos_reg);
        sps_w     = CW'(eff_sps);
        pps_at    = sps_w + CW'(avcc2ab_pkg::PPS_LEN_GAP);
        sps_next  = eff_sps;
        pps_next  = eff_pps;
        bad_next  = eff_bad;
        wr_hit    = 1'b0;
        wr_addr_w = '0;

        if (pos_w == CW'(avcc2ab_pkg::SPS_LEN_POS)) begin
            sps_next = data_byte;
            if (CW'(data_byte) + CW'(avcc2ab_pkg::PREFIX_BYTES) > CW'(STORE_BYTES)) begin
                bad_next = 1'b1;
            end
        end else if (pos_w >= CW'(avcc2ab_pkg::SETS_START) &&
                     pos_w < sps_w + CW'(avcc2ab_pkg::SETS_START)) begin
            // SPS byte lands behind the first prefix
            wr_hit    = !eff_bad;
            wr_addr_w = pos_w - CW'(avcc2ab_pkg::PREFIX_BYTES);
        end else if (pos_w == pps_at) begin
            pps_next = data_byte;
            if (sps_w + CW'(data_byte) + CW'(avcc2ab_pkg::SETS_START) > CW'(STORE_BYTES)) begin
                bad_next = 1'b1;
            end
        end else if (pos_w > pps_at && pos_w < pps_at + CW'(1) + CW'(eff_pps)) begin
            // PPS byte lands behind the second prefix
            wr_hit    = !eff_bad;
            wr_addr_w = pos_w - CW'(avcc2ab_pkg::PREFIX_BYTES - 1);
        end

        whole = pos_w >= CW'(avcc2ab_pkg::SETS_START) && pos_w >= pps_at &&
                pos_w + CW'(1) >= pps_at + CW'(1) + CW'(pps_next);
        good  = whole && !bad_next;
        len_w = CW'(avcc2ab_pkg::SETS_START) + CW'(sps_next) + CW'(pps_next);

        status = (last && !good) ? avcc2ab_pkg::STAT_BAD_EXTRA : avcc2ab_pkg::STAT_OK;

        if (last) begin
            extra_pos_next = '0;
        end else if (&extra_pos_reg) begin
            extra_pos_next = extra_pos_reg;
        end else begin
            extra_pos_next = extra_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extra_pos_reg <= '0;
            sps_reg       <= '0;
            pps_reg       <= '0;
            bad_reg       <= 1'b0;
            valid_reg     <= 1'b0;
        end else if (acc) begin
            extra_pos_reg <= extra_pos_next;
            sps_reg       <= sps_next;
            pps_reg       <= pps_next;
            bad_reg       <= bad_next;
            if (last && good) begin
                valid_reg <= 1'b1;
            end else if (first) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            param_length_reg <= '0;
        end else if (acc && last && good) begin
            param_length_reg <= len_w[PLW-1:0];
        end
    end

    assign wr_en          = acc && wr_hit;
    assign wr_addr        = wr_addr_w[AW-1:0];
    assign wr_data        = data_byte;
    assign sets.valid     = valid_reg;
    assign sets.sps_bytes = sps_reg;
    assign param_length   = param_length_reg;

endmodule

// ===== src/avcc2ab_pkt_parser.sv =====
// Packet parser: tracks lengths and payload counts, plans each byte's results.
`timescale 1ns / 1ps

module avcc2ab_pkt_parser #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 acc,
    input  logic [7:0]           data_byte,
    input  logic                 last,
    input  logic                 key_frame,
    input  logic [23:0]          packet_length,
    input  logic                 params_valid,
    output avcc2ab_pkg::plan_t   plan
);

    localparam int LB = LENGTH_BITS;
    localparam int SW = 34;

    logic [LB-1:0] pos_reg, total_reg;
    logic [31:0]   shift_reg, left_reg;
    logic [1:0]    have_reg;
    logic          drop_reg;
    logic [1:0]    stat_reg;

    logic          first;
    logic [LB-1:0] total_e, pos_inc;
    logic [31:0]   shift_e, left_e, shift_new;
    logic [31:0]   shift_next, left_next;
    logic [1:0]    have_e, have_next;
    logic          drop_e, drop_next;
    logic [1:0]    stat_e, stat_next, final_stat;
    avcc2ab_pkg::tail_t tail;

    always_comb begin
        first     = (pos_reg == '0);
        total_e   = first ? LB'(packet_length) : total_reg;
        have_e    = first ? 2'd0 : have_reg;
        shift_e   = first ? 32'd0 : shift_reg;
        left_e    = first ? 32'd0 : left_reg;
        drop_e    = first ? !params_valid : drop_reg;
        stat_e    = first ? (params_valid ? avcc2ab_pkg::STAT_OK : avcc2ab_pkg::STAT_NO_SETS)
                          : stat_reg;
        have_next  = have_e;
        shift_next = shift_e;
        left_next  = left_e;
        drop_next  = drop_e;
        stat_next  = stat_e;
        shift_new  = {shift_e[23:0], data_byte};
        tail       = avcc2ab_pkg::TAIL_NONE;

        if (!drop_e && pos_reg < total_e) begin
            if (left_e != 32'd0) begin
                tail      = avcc2ab_pkg::TAIL_DATA;
                left_next = left_e - 32'd1;
            end else if (have_e == 2'd0 &&
                         (total_e - pos_reg) < LB'(avcc2ab_pkg::LEN_BYTES)) begin
                // short tail: no room for another length
                drop_next = 1'b1;
                stat_next = avcc2ab_pkg::STAT_TRUNC;
            end else if (have_e == 2'(avcc2ab_pkg::LEN_BYTES - 1)) begin
                tail       = avcc2ab_pkg::TAIL_CODE;
                have_next  = 2'd0;
                shift_next = 32'd0;
                if (SW'(pos_reg) + SW'(1) + SW'(shift_new) > SW'(total_e)) begin
                    // overrun: start code still goes out, rest dropped
                    drop_next = 1'b1;
                    stat_next = avcc2ab_pkg::STAT_TRUNC;
                end else begin
                    left_next = shift_new;
                end
            end else begin
                have_next  = have_e + 2'd1;
                shift_next = shift_new;
            end
        end

        pos_inc = (&pos_reg) ? pos_reg : pos_reg + 1'b1;

        if (stat_next == avcc2ab_pkg::STAT_OK && pos_inc < total_e) begin
            final_stat = avcc2ab_pkg::STAT_TRUNC;
        end else begin
            final_stat = stat_next;
        end

        plan.replay = first && params_valid && key_frame;
        plan.tail   = tail;
        plan.last   = last;
        plan.status = last ? final_stat : avcc2ab_pkg::STAT_OK;
        plan.data   = data_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            total_reg <= '0;
            shift_reg <= '0;
            left_reg  <= '0;
            have_reg  <= '0;
            drop_reg  <= 1'b0;
            stat_reg  <= avcc2ab_pkg::STAT_OK;
        end else if (acc) begin
            total_reg <= total_e;
            if (last) begin
                pos_reg   <= '0;
                shift_reg <= '0;
                left_reg  <= '0;
                have_reg  <= '0;
                drop_reg  <= 1'b0;
                stat_reg  <= avcc2ab_pkg::STAT_OK;
            end else begin
                pos_reg   <= pos_inc;
                shift_reg <= shift_next;
                left_reg  <= left_next;
                have_reg  <= have_next;
                drop_reg  <= drop_next;
                stat_reg  <= stat_next;
            end
        end
    end

endmodule

// ===== src/avcc_to_annexb_converter_unit.sv =====
// Top level of the length-prefix to start-code converter.
`timescale 1ns / 1ps

// Converts length-prefixed H.264 into a start-code byte stream.
// Input channel (s_*): one byte per request. s_action low marks an extradata
// byte, high a packet byte; s_last flags the final byte of the unit, and
// s_key_frame / s_packet_length are taken on a packet's first byte.
// Output channel (m_*): one byte per request. m_byte_valid low means a bare
// end marker; m_end_of_unit flags the last result of a unit and m_status
// carries its outcome (zero on every other result).
// Timing: a request that makes at most one result is taken every cycle while
// the output register drains, so payload bytes stream at one per cycle into
// the registered output. A completed length sends the start code 00 00 00 01.
// A key frame's first byte replays the stored sets from the store's single
// read port, one stored byte per cycle while the output register drains.
// s_ready is low while such a multi-result sequence is in flight.
// Reset: no parameter sets are held, so packets are dropped with status 2
// until a good extradata unit arrives; the store itself is not cleared.
// Stall: the output register holds its result while m_ready is low; the
// sequencer waits, and the input is taken again once the sequence is out.

module avcc_to_annexb_converter_unit #(
    parameter int STORE_BYTES = 64,
    parameter int LENGTH_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    input  logic        s_key_frame,
    input  logic [23:0] s_packet_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_end_of_unit,
    output logic [1:0]  m_status
);

    localparam int AW  = $clog2(STORE_BYTES);
    localparam int PLW = $clog2(STORE_BYTES + 1);
    localparam int CW  = (PLW > 9) ? PLW : 9;

    // Handshake and routing
    logic acc, ext_acc, pkt_acc, out_free;

    // Store ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [7:0]    rd_data;

    // Parser views
    logic [1:0]         ext_status;
    avcc2ab_pkg::sets_t sets;
    logic [PLW-1:0]     param_length;
    avcc2ab_pkg::plan_t pkt_plan, ext_plan, plan_sel;

    // Sequencer
    avcc2ab_pkg::state_t state_reg, state_next;
    avcc2ab_pkg::plan_t  plan_reg, plan_next;
    logic [PLW-1:0]      rd_idx_reg, rd_idx_next;
    logic [PLW-1:0]      hold_idx_reg, hold_idx_next;
    logic                hold_vld_reg, hold_vld_next;
    logic [1:0]          tail_cnt_reg, tail_cnt_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_out_byte_reg;
    logic       m_byte_valid_reg, m_end_reg;
    logic [1:0] m_status_reg;
    logic       out_load;
    logic [7:0] out_byte_next;
    logic       out_bv_next, out_end_next;
    logic [1:0] out_stat_next;

    // Replay byte selection
    logic [CW-1:0] idx_w, sps_w;
    logic [7:0]    replay_byte;
    logic          replay_end, last_replay;

    assign s_ready  = (state_reg == avcc2ab_pkg::ST_IDLE);
    assign acc      = s_valid && s_ready;
    assign ext_acc  = acc && !s_action;
    assign pkt_acc  = acc && s_action;
    assign out_free = !m_valid_reg || m_ready;

    avcc2ab_param_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    avcc2ab_extra_parser #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW),
        .PLW         (PLW)
    ) u_extra (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .acc          (ext_acc),
        .data_byte    (s_data_byte),
        .last         (s_last),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .status       (ext_status),
        .sets         (sets),
        .param_length (param_length)
    );

    avcc2ab_pkt_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_pkt (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .acc           (pkt_acc),
        .data_byte     (s_data_byte),
        .last          (s_last),
        .key_frame     (s_key_frame),
        .packet_length (s_packet_length),
        .params_valid  (sets.valid),
        .plan          (pkt_plan)
    );

    // Extradata only ever makes an end marker
    always_comb begin
        ext_plan.replay = 1'b0;
        ext_plan.tail   = avcc2ab_pkg::TAIL_NONE;
        ext_plan.last   = s_last;
        ext_plan.status = ext_status;
        ext_plan.data   = s_data_byte;
        plan_sel        = s_action ? pkt_plan : ext_plan;
    end

    // Replayed sets carry synthesized 00 00 00 01 prefixes at both set heads
    always_comb begin
        idx_w = CW'(hold_idx_reg);
        sps_w = CW'(sets.sps_bytes);
        if (idx_w < CW'(avcc2ab_pkg::PREFIX_BYTES)) begin
            replay_byte = (idx_w == CW'(avcc2ab_pkg::PREFIX_BYTES - 1)) ?
                          avcc2ab_pkg::START_CODE_LAST : 8'd0;
        end else if (idx_w >= sps_w + CW'(avcc2ab_pkg::PREFIX_BYTES) &&
                     idx_w < sps_w + CW'(avcc2ab_pkg::SETS_START)) begin
            replay_byte = (idx_w == sps_w + CW'(avcc2ab_pkg::SETS_START - 1)) ?
                          avcc2ab_pkg::START_CODE_LAST : 8'd0;
        end else begin
            replay_byte = rd_data;
        end
        last_replay = (hold_idx_reg + 1'b1 == param_length);
        replay_end  = plan_reg.last && plan_reg.tail == avcc2ab_pkg::TAIL_NONE && last_replay;
    end

    always_comb begin
        state_next    = state_reg;
        plan_next     = plan_reg;
        rd_idx_next   = rd_idx_reg;
        hold_idx_next = hold_idx_reg;
        hold_vld_next = hold_vld_reg;
        tail_cnt_next = tail_cnt_reg;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        out_byte_next = 8'd0;
        out_bv_next   = 1'b0;
        out_end_next  = 1'b0;
        out_stat_next = avcc2ab_pkg::STAT_OK;

        unique case (state_reg)
            avcc2ab_pkg::ST_IDLE: begin
                if (acc) begin
                    plan_next = plan_sel;
                    if (plan_sel.replay) begin
                        state_next    = avcc2ab_pkg::ST_REPLAY;
                        rd_idx_next   = '0;
                        hold_vld_next = 1'b0;
                    end else if (plan_sel.tail == avcc2ab_pkg::TAIL_CODE) begin
                        state_next    = avcc2ab_pkg::ST_TAIL;
                        tail_cnt_next = 2'd0;
                    end else if (plan_sel.tail == avcc2ab_pkg::TAIL_DATA) begin
                        // single payload byte: pass straight through when the slot is free
                        if (out_free) begin
                            out_load      = 1'b1;
                            out_byte_next = plan_sel.data;
                            out_bv_next   = 1'b1;
                            out_end_next  = plan_sel.last;
                            out_stat_next = plan_sel.status;
                        end else begin
                            state_next = avcc2ab_pkg::ST_TAIL;
                        end
                    end else if (plan_sel.last) begin
                        if (out_free) begin
                            out_load      = 1'b1;
                            out_end_next  = 1'b1;
                            out_stat_next = plan_sel.status;
                        end else begin
                            state_next = avcc2ab_pkg::ST_MARK;
                        end
                    end
                end
            end

            avcc2ab_pkg::ST_REPLAY: begin
                // read one stored byte ahead of the output register
                rd_en = (rd_idx_reg < param_length) && (!hold_vld_reg || out_free);
                if (hold_vld_reg && out_free) begin
                    out_load      = 1'b1;
                    out_byte_next = replay_byte;
                    out_bv_next   = 1'b1;
                    out_end_next  = replay_end;
                    out_stat_next = replay_end ? plan_reg.status : avcc2ab_pkg::STAT_OK;
                    hold_vld_next = 1'b0;
                end
                if (rd_en) begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    hold_idx_next = rd_idx_reg;
                    hold_vld_next = 1'b1;
                end
                if (rd_idx_reg == param_length && (!hold_vld_reg || out_free)) begin
                    tail_cnt_next = 2'd0;
                    state_next    = (plan_reg.tail == avcc2ab_pkg::TAIL_NONE) ?
                                    avcc2ab_pkg::ST_IDLE : avcc2ab_pkg::ST_TAIL;
                end
            end

            avcc2ab_pkg::ST_TAIL: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_bv_next = 1'b1;
                    if (plan_reg.tail == avcc2ab_pkg::TAIL_DATA) begin
                        out_byte_next = plan_reg.data;
                        out_end_next  = plan_reg.last;
                        out_stat_next = plan_reg.status;
                        state_next    = avcc2ab_pkg::ST_IDLE;
                    end else begin
                        out_byte_next = (tail_cnt_reg == 2'(avcc2ab_pkg::LEN_BYTES - 1)) ?
                                        avcc2ab_pkg::START_CODE_LAST : 8'd0;
                        if (tail_cnt_reg == 2'(avcc2ab_pkg::LEN_BYTES - 1)) begin
                            out_end_next  = plan_reg.last;
                            out_stat_next = plan_reg.status;
                            state_next    = avcc2ab_pkg::ST_IDLE;
                        end
                        tail_cnt_next = tail_cnt_reg + 2'd1;
                    end
                end
            end

            avcc2ab_pkg::ST_MARK: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_end_next  = 1'b1;
                    out_stat_next = plan_reg.status;
                    state_next    = avcc2ab_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = avcc2ab_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= avcc2ab_pkg::ST_IDLE;
            hold_vld_reg <= 1'b0;
            rd_idx_reg   <= '0;
            tail_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hold_vld_reg <= hold_vld_next;
            rd_idx_reg   <= rd_idx_next;
            tail_cnt_reg <= tail_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload: hold the plan and the result until replaced
    always_ff @(posedge aclk) begin
        plan_reg     <= plan_next;
        hold_idx_reg <= hold_idx_next;
        if (out_load) begin
            m_out_byte_reg   <= out_byte_next;
            m_byte_valid_reg <= out_bv_next;
            m_end_reg        <= out_end_next;
            m_status_reg     <= out_stat_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_byte_valid  = m_byte_valid_reg;
    assign m_end_of_unit = m_end_reg;
    assign m_status      = m_status_reg;

    // A new request must never find a stored byte still waiting to go out
    a_ready_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !hold_vld_reg)
        else $error("request taken while a replay byte is pending");

    // Replay reads stay inside the stored sets
    a_rd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == avcc2ab_pkg::ST_REPLAY) |-> (rd_idx_reg <= param_length))
        else $error("replay read past the stored sets");

    // Replay only runs while valid sets are held
    a_replay_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == avcc2ab_pkg::ST_REPLAY) |-> sets.valid)
        else $error("replay without valid parameter sets");

    // A bare marker always closes a unit
    a_marker_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> m_end_of_unit)
        else $error("marker without end of unit");

    // Non-zero status appears on the closing result only
    a_status_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != avcc2ab_pkg::STAT_OK) |-> m_end_of_unit)
        else $error("status on a result that does not end the unit");

endmodule
